[rtl/core/ljpf_pkg.sv]
// Shared types, constants and saturating helpers of the Lennard-Jones pair force block.
`timescale 1ns / 1ps
package ljpf_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_RCSQ,
    ST_DECIDE,
    ST_SQRT,
    ST_GDIV,
    ST_G2,
    ST_G3,
    ST_G6,
    ST_G12,
    ST_AMP,
    ST_FMUL,
    ST_FDIV,
    ST_EMUL,
    ST_STAT,
    ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_RUN,
    PH_DONE
  } ph_t;

  typedef enum logic [1:0] {
    U_NONE,
    U_MUL,
    U_DIV,
    U_SQRT
  } unit_t;

  typedef enum logic [2:0] {
    CFG_BOX_X,
    CFG_BOX_Y,
    CFG_BOX_Z,
    CFG_WRAP,
    CFG_CUTOFF,
    CFG_EPS,
    CFG_SHIFT,
    CFG_STAT
  } cfg_idx_t;

  typedef struct packed {
    unit_t unit;
    logic  load;
    logic  step;
    logic  done;
    logic  last;
  } ctl_t;

  localparam int CNT_BITS = 6;
  localparam logic [CNT_BITS-1:0] MUL_LAST  = 6'd15;
  localparam logic [CNT_BITS-1:0] DIV_LAST  = 6'd63;
  localparam logic [CNT_BITS-1:0] SQRT_LAST = 6'd31;

  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] F_MAX   = 64'h0000_7FFF_FFFF_FFFF;

  // Result word layout, lowest bit first
  localparam int OUT_W   = 304;
  localparam int O_ID1   = 0;
  localparam int O_ID2   = 16;
  localparam int O_FX    = 32;
  localparam int O_FY    = 80;
  localparam int O_FZ    = 128;
  localparam int O_POT   = 176;
  localparam int O_VIR   = 240;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] to_signed64(input logic [63:0] mag, input logic neg);
    logic [63:0] v;
    v = mag[63] ? I64_MAX : mag;
    return neg ? (64'd0 - v) : v;
  endfunction

endpackage

[rtl/core/lennard_jones_pair_force_3d.sv]
// Lennard-Jones pair force with cutoff and periodic box, digit-serial datapath.
// A skipped pair goes straight to the result; a pair out of range on an axis leaves
// after the axis differences, and one outside the cutoff after the distance test.
// One pair at a time; the 4-bit-digit multiplier and the radix-2 divider set the
// pace of a pair inside the cutoff.
// Reset (rst_n low, synchronous) restores register defaults and clears both sums.
`timescale 1ns / 1ps
module lennard_jones_pair_force_3d #(
  parameter int ID_BITS    = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // tdata: first_id, second_id, first_x, first_y, first_z, second_x, second_y,
  // second_z, first_radius, second_radius, zero pad to bytes
  input  logic [((2*ID_BITS+6*COORD_BITS+48+7)/8)*8-1:0] in_tdata,
  // tuser: bit0 frame_start, bit1 pair_skipped
  input  logic [1:0]                in_tuser,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // tdata: out_first_id, out_second_id, force_x, force_y, force_z,
  // potential_sum, virial_sum
  output logic [ljpf_pkg::OUT_W-1:0] out_tdata,
  // tuser: bit0 in_range
  output logic                      out_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  ljpf_pkg::cfg_idx_t        cfg_index,
  input  logic [31:0]               cfg_data
);
  import ljpf_pkg::*;

  localparam int DW   = ((COORD_BITS > 32) ? COORD_BITS : 32) + 2;
  localparam int P_X1 = 2*ID_BITS;
  localparam int P_R1 = 2*ID_BITS + 6*COORD_BITS;

  // configuration
  logic [31:0] box_x_r, box_y_r, box_z_r, shift_r;
  logic [2:0]  wrap_r;
  logic [15:0] cutoff_r;
  logic [23:0] eps_r;
  logic [1:0]  stat_r;

  // control
  st_t                 state_r, state_nxt;
  ph_t                 ph_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [1:0]          axis_r;
  ctl_t                ctl;
  logic                out_valid_r;

  // item registers
  logic [ID_BITS-1:0]           id1_r, id2_r;
  logic signed [COORD_BITS-1:0] pa_r [3];
  logic signed [COORD_BITS-1:0] pb_r [3];
  logic [24:0]                  sumr_r;
  logic [29:0]                  ad_r [3];
  logic [2:0]                   dneg_r;
  logic                         far_r, hit_r;
  logic [63:0]                  rsq_r, rcsq_r, g_r, t_r, g6_r, g12_r, p_r, e4_r;
  logic                         aneg_r;
  logic [31:0]                  r_r;
  logic [47:0]                  force_r [3];
  logic [63:0]                  pot_r, vir_r;
  logic [OUT_W-1:0]             out_data_r;
  logic                         out_user_r;

  // shared arithmetic units
  logic [63:0]  ma_r, mb_r, dd_r, q_r;
  logic [127:0] acc_r;
  logic         dsat_r;
  logic [63:0]  sv_r, sres_r, sbit_r;

  logic [63:0] mul_a, mul_b;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------- axis diff
  logic signed [COORD_BITS-1:0] pa_sel, pb_sel;
  logic [31:0]                  wid_sel;
  logic                         wrap_sel;
  logic signed [DW-1:0]         dd, alt, nd;
  logic [DW-1:0]                adu, nadu;
  logic                         far_now;

  always_comb begin
    pa_sel   = pa_r[axis_r];
    pb_sel   = pb_r[axis_r];
    wrap_sel = wrap_r[axis_r];
    unique case (axis_r)
      2'd0:    wid_sel = box_x_r;
      2'd1:    wid_sel = box_y_r;
      default: wid_sel = box_z_r;
    endcase
    dd  = DW'(pa_sel) - DW'(pb_sel);
    adu = dd[DW-1] ? DW'(-dd) : DW'(dd);
    alt = $signed(DW'(wid_sel)) - $signed(adu);
    if (wrap_sel && (alt < $signed(adu))) begin
      nd = (dd > 0) ? -alt : alt;
    end else begin
      nd = dd;
    end
    nadu    = nd[DW-1] ? DW'(-nd) : DW'(nd);
    far_now = |nadu[DW-1:30];
  end

  // ---------------------------------------------------------------- helpers
  logic [40:0]  rc_full;
  logic [28:0]  rc;
  logic [64:0]  two_full;
  logic [63:0]  two, amag, dmag;
  logic         aneg, dneg_e;
  logic [63:0]  sh32, sh16;
  logic [68:0]  x24;
  logic [63:0]  p24, e4;
  logic [63:0]  mq;
  logic [46:0]  mc;
  logic [47:0]  fval;
  logic [63:0]  shift64, term;

  always_comb begin
    rc_full  = 41'(sumr_r) * 41'(cutoff_r);
    rc       = rc_full[40:12];
    two_full = {g12_r, 1'b0};
    two      = two_full[64] ? U64_MAX : two_full[63:0];
    aneg     = two < g6_r;
    amag     = aneg ? (g6_r - two) : (two - g6_r);
    dneg_e   = g12_r < g6_r;
    dmag     = dneg_e ? (g6_r - g12_r) : (g12_r - g6_r);
    sh32     = (|acc_r[127:96]) ? U64_MAX : acc_r[95:32];
    sh16     = (|acc_r[127:80]) ? U64_MAX : acc_r[79:16];
    x24      = {1'b0, sh16, 4'b0} + {2'b0, sh16, 3'b0};
    p24      = (|x24[68:64]) ? U64_MAX : x24[63:0];
    e4       = (|sh16[63:62]) ? U64_MAX : {sh16[61:0], 2'b0};
    mq       = dsat_r ? U64_MAX : q_r;
    mc       = (mq > F_MAX) ? F_MAX[46:0] : mq[46:0];
    if (ad_r[axis_r] == 30'd0) mc = '0;
    fval     = (aneg_r ^ dneg_r[axis_r]) ? (48'd0 - {1'b0, mc}) : {1'b0, mc};
    shift64  = {{16{shift_r[31]}}, shift_r, 16'b0};
    term     = sat_add64(to_signed64(e4_r, dneg_e), 64'd0 - shift64);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        mul_a = 64'(ad_r[axis_r]);
        mul_b = 64'(ad_r[axis_r]);
      end
      ST_RCSQ: begin
        mul_a = 64'(rc);
        mul_b = 64'(rc);
      end
      ST_G2: begin
        mul_a = g_r;
        mul_b = g_r;
      end
      ST_G3: begin
        mul_a = t_r;
        mul_b = g_r;
      end
      ST_G6: begin
        mul_a = t_r;
        mul_b = t_r;
      end
      ST_G12: begin
        mul_a = g6_r;
        mul_b = g6_r;
      end
      ST_AMP: begin
        mul_a = amag;
        mul_b = 64'(eps_r);
      end
      ST_FMUL: begin
        mul_a = p_r;
        mul_b = {26'b0, ad_r[axis_r], 8'b0};
      end
      ST_EMUL: begin
        mul_a = dmag;
        mul_b = 64'(eps_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_SQ, ST_RCSQ, ST_G2, ST_G3, ST_G6, ST_G12,
      ST_AMP, ST_FMUL, ST_EMUL: ctl.unit = U_MUL;
      ST_GDIV, ST_FDIV:         ctl.unit = U_DIV;
      ST_SQRT:                  ctl.unit = U_SQRT;
      default:                  ctl.unit = U_NONE;
    endcase
    if (ctl.unit != U_NONE) begin
      ctl.load = (ph_r == PH_LOAD);
      ctl.step = (ph_r == PH_RUN);
      ctl.done = (ph_r == PH_DONE);
    end
    unique case (ctl.unit)
      U_MUL:   ctl.last = (cnt_r == MUL_LAST);
      U_DIV:   ctl.last = (cnt_r == DIV_LAST);
      U_SQRT:  ctl.last = (cnt_r == SQRT_LAST);
      default: ctl.last = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = in_tuser[1] ? ST_OUT : ST_DIFF;
      ST_DIFF:   if (axis_r == 2'd2) state_nxt = (far_r || far_now) ? ST_OUT : ST_SQ;
      ST_SQ:     if (ctl.done && axis_r == 2'd2) state_nxt = ST_RCSQ;
      ST_RCSQ:   if (ctl.done) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = (rsq_r != 64'd0 && rsq_r < rcsq_r) ? ST_SQRT : ST_OUT;
      ST_SQRT:   if (ctl.done) state_nxt = ST_GDIV;
      ST_GDIV:   if (ctl.done) state_nxt = ST_G2;
      ST_G2:     if (ctl.done) state_nxt = ST_G3;
      ST_G3:     if (ctl.done) state_nxt = ST_G6;
      ST_G6:     if (ctl.done) state_nxt = ST_G12;
      ST_G12:    if (ctl.done) state_nxt = ST_AMP;
      ST_AMP:    if (ctl.done) state_nxt = ST_FMUL;
      ST_FMUL:   if (ctl.done) state_nxt = ST_FDIV;
      ST_FDIV: begin
        if (ctl.done) begin
          if (axis_r != 2'd2) state_nxt = ST_FMUL;
          else                state_nxt = stat_r[0] ? ST_EMUL : ST_STAT;
        end
      end
      ST_EMUL:   if (ctl.done) state_nxt = ST_STAT;
      ST_STAT:   state_nxt = ST_OUT;
      ST_OUT:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_LOAD;
      cnt_r       <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
      box_x_r     <= 32'd4194304;
      box_y_r     <= 32'd4194304;
      box_z_r     <= 32'd4194304;
      wrap_r      <= 3'd7;
      cutoff_r    <= 16'd10240;
      eps_r       <= 24'd65536;
      shift_r     <= '0;
      stat_r      <= '0;
      pot_r       <= '0;
      vir_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BOX_X:  box_x_r  <= cfg_data;
          CFG_BOX_Y:  box_y_r  <= cfg_data;
          CFG_BOX_Z:  box_z_r  <= cfg_data;
          CFG_WRAP:   wrap_r   <= cfg_data[2:0];
          CFG_CUTOFF: cutoff_r <= cfg_data[15:0];
          CFG_EPS:    eps_r    <= cfg_data[23:0];
          CFG_SHIFT:  shift_r  <= cfg_data;
          CFG_STAT:   stat_r   <= cfg_data[1:0];
        endcase
      end

      // unit phase sequencing
      if (ctl.load) begin
        ph_r  <= PH_RUN;
        cnt_r <= '0;
      end else if (ctl.step) begin
        if (ctl.last) ph_r <= PH_DONE;
        cnt_r <= cnt_r + 1'b1;
      end else if (ctl.done) begin
        ph_r <= PH_LOAD;
      end

      // advance the axis index on each per-axis completion
      if ((state_r == ST_DIFF) ||
          (ctl.done && (state_r == ST_SQ || state_r == ST_FDIV))) begin
        axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 1'b1;
      end

      if (state_r == ST_IDLE && in_tvalid && in_tuser[0]) begin
        pot_r <= '0;
        vir_r <= '0;
      end
      if (state_r == ST_STAT) begin
        if (stat_r[0]) pot_r <= sat_add64(pot_r, term);
        if (stat_r[1]) vir_r <= sat_add64(vir_r, to_signed64(p_r, aneg_r));
      end

      if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset
  logic [68:0]  part_sum;
  logic [67:0]  partial;
  logic [128:0] acc_sh;
  logic [127:0] dv_sh;
  logic         dv_ge;
  logic [63:0]  dv_hi;
  logic [63:0]  sq_try;
  logic [ID_BITS+15:0] id1_ext, id2_ext;

  always_comb begin
    partial  = 68'(ma_r) * 68'(mb_r[3:0]);
    part_sum = 69'(acc_r[127:64]) + 69'(partial);
    acc_sh   = {part_sum, acc_r[63:4]};
    dv_sh    = {acc_r[126:0], 1'b0};
    dv_ge    = acc_r[127] || (dv_sh[127:64] >= dd_r);
    dv_hi    = dv_ge ? (dv_sh[127:64] - dd_r) : dv_sh[127:64];
    sq_try   = sres_r + sbit_r;
    id1_ext  = {16'b0, id1_r};
    id2_ext  = {16'b0, id2_r};
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      id1_r   <= in_tdata[0 +: ID_BITS];
      id2_r   <= in_tdata[ID_BITS +: ID_BITS];
      pa_r[0] <= in_tdata[P_X1 +: COORD_BITS];
      pa_r[1] <= in_tdata[P_X1 + COORD_BITS +: COORD_BITS];
      pa_r[2] <= in_tdata[P_X1 + 2*COORD_BITS +: COORD_BITS];
      pb_r[0] <= in_tdata[P_X1 + 3*COORD_BITS +: COORD_BITS];
      pb_r[1] <= in_tdata[P_X1 + 4*COORD_BITS +: COORD_BITS];
      pb_r[2] <= in_tdata[P_X1 + 5*COORD_BITS +: COORD_BITS];
      sumr_r  <= 25'(in_tdata[P_R1 +: 24]) + 25'(in_tdata[P_R1 + 24 +: 24]);
      far_r   <= 1'b0;
      hit_r   <= 1'b0;
      rsq_r   <= '0;
      for (int k = 0; k < 3; k++) force_r[k] <= '0;
    end

    if (state_r == ST_DIFF) begin
      ad_r[axis_r]   <= nadu[29:0];
      dneg_r[axis_r] <= nd[DW-1];
      far_r          <= far_r | far_now;
    end

    if (state_r == ST_DECIDE) hit_r <= (rsq_r != 64'd0 && rsq_r < rcsq_r);

    // multiplier: low digit of the second operand first
    if (ctl.load && ctl.unit == U_MUL) begin
      ma_r  <= mul_a;
      mb_r  <= mul_b;
      acc_r <= '0;
    end else if (ctl.step && ctl.unit == U_MUL) begin
      mb_r  <= {4'b0, mb_r[63:4]};
      acc_r <= acc_sh[127:0];
    end

    // divider over the 128-bit accumulator
    if (ctl.load && ctl.unit == U_DIV) begin
      if (state_r == ST_GDIV) begin
        acc_r  <= {64'b0, 7'b0, sumr_r, 32'b0};
        dd_r   <= 64'(r_r);
        dsat_r <= 1'b0;
      end else begin
        dd_r   <= rsq_r;
        dsat_r <= (acc_r[127:64] >= rsq_r);
      end
      q_r <= '0;
    end else if (ctl.step && ctl.unit == U_DIV) begin
      acc_r <= {dv_hi, dv_sh[63:0]};
      q_r   <= {q_r[62:0], dv_ge};
    end

    // square root, two bits of the radicand a step
    if (ctl.load && ctl.unit == U_SQRT) begin
      sv_r   <= rsq_r;
      sres_r <= '0;
      sbit_r <= 64'h4000_0000_0000_0000;
    end else if (ctl.step && ctl.unit == U_SQRT) begin
      if (sv_r >= sq_try) begin
        sv_r   <= sv_r - sq_try;
        sres_r <= {1'b0, sres_r[63:1]} + sbit_r;
      end else begin
        sres_r <= {1'b0, sres_r[63:1]};
      end
      sbit_r <= {2'b0, sbit_r[63:2]};
    end

    if (ctl.done) begin
      unique case (state_r)
        ST_SQ:   rsq_r  <= rsq_r + acc_r[63:0];
        ST_RCSQ: rcsq_r <= acc_r[63:0];
        ST_SQRT: r_r    <= sres_r[31:0];
        ST_GDIV: g_r    <= q_r;
        ST_G2:   t_r    <= sh32;
        ST_G3:   t_r    <= sh32;
        ST_G6:   g6_r   <= sh32;
        ST_G12:  g12_r  <= sh32;
        ST_AMP: begin
          p_r    <= p24;
          aneg_r <= aneg;
        end
        ST_FDIV: force_r[axis_r] <= fval;
        ST_EMUL: e4_r <= e4;
        default: begin
        end
      endcase
    end

    if (state_r == ST_OUT && (!out_valid_r || out_tready)) begin
      out_data_r[O_ID1 +: 16] <= id1_ext[15:0];
      out_data_r[O_ID2 +: 16] <= id2_ext[15:0];
      out_data_r[O_FX  +: 48] <= force_r[0];
      out_data_r[O_FY  +: 48] <= force_r[1];
      out_data_r[O_FZ  +: 48] <= force_r[2];
      out_data_r[O_POT +: 64] <= pot_r;
      out_data_r[O_VIR +: 64] <= vir_r;
      out_user_r              <= hit_r;
    end
  end

endmodule

[rtl/core/ljpf_checker.sv]
// Port-level checker for the pair force block and its bind.
`timescale 1ns / 1ps
module ljpf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [ljpf_pkg::OUT_W-1:0]  out_tdata,
  input logic                        out_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready
);
  import ljpf_pkg::*;

  // one pair in flight: input closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a pair is in flight");

  // a pair not in range (skipped, far on an axis or outside the cutoff) carries no force
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[O_POT-1:O_FX] == '0)
    else $error("force present on an out-of-range pair");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind lennard_jones_pair_force_3d ljpf_checker u_ljpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
